// ===== rtl/core/utf8_unicode_escaper_defines.svh =====
// Assertion macros for the escaper checker.
// Depends on nothing; included by the checker file only.
`ifndef UTF8_UNICODE_ESCAPER_DEFINES_SVH
`define UTF8_UNICODE_ESCAPER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define UUE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("escaper check failed");

// next-cycle implication
`define UUE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("escaper check failed");

`endif

// ===== rtl/core/uue_pkg.sv =====
// Shared types, character codes and helper functions of the escaper.
// No dependencies; imported by all design modules but the checker.
package uue_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned CharW  = 7;
  localparam int unsigned StepW  = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_STRIP_BOM = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LATIN1    = 2'd1;

  localparam logic [CharW-1:0] CH_BACKSLASH = 7'h5c;
  localparam logic [CharW-1:0] CH_LOWER_U   = 7'h75;
  localparam logic [CharW-1:0] CH_UPPER_U   = 7'h55;
  localparam logic [CharW-1:0] CH_NONE      = 7'h00;

  localparam logic [CpW-1:0] CP_BOM      = 21'h00feff;
  localparam logic [CpW-1:0] CP_BMP_MAX  = 21'h00ffff;
  localparam logic [CpW-1:0] CP_PRINT_LO = 21'd32;
  localparam logic [CpW-1:0] CP_PRINT_HI = 21'd126;

  localparam logic [7:0] LEAD_E0 = 8'he0;
  localparam logic [7:0] LEAD_ED = 8'hed;
  localparam logic [7:0] LEAD_F0 = 8'hf0;
  localparam logic [7:0] LEAD_F4 = 8'hf4;

  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_LETTER,
    KIND_HEX4,
    KIND_HEX8,
    KIND_MARK
  } kind_e;

  typedef struct packed {
    kind_e          kind;
    logic [CpW-1:0] cp;
    logic           done;
    logic           bad;
  } job_t;

  typedef struct packed {
    logic drop_bom;
    logic latin1;
  } cfg_t;

  function automatic logic [CharW-1:0] letter_of(logic [CpW-1:0] cp);
    logic [CharW-1:0] ch;
    ch = CH_NONE;
    if (cp[CpW-1:CharW] == '0) begin
      unique case (cp[CharW-1:0])
        7'h07:   ch = 7'h61;
        7'h08:   ch = 7'h62;
        7'h09:   ch = 7'h74;
        7'h0a:   ch = 7'h6e;
        7'h0b:   ch = 7'h76;
        7'h0c:   ch = 7'h66;
        7'h0d:   ch = 7'h72;
        7'h22:   ch = 7'h22;
        7'h27:   ch = 7'h27;
        7'h5c:   ch = 7'h5c;
        default: ch = CH_NONE;
      endcase
    end
    return ch;
  endfunction

  function automatic kind_e classify(logic [CpW-1:0] cp);
    kind_e k;
    if (letter_of(cp) != CH_NONE) k = KIND_LETTER;
    else if (cp >= CP_PRINT_LO && cp <= CP_PRINT_HI) k = KIND_PLAIN;
    else if (cp <= CP_BMP_MAX) k = KIND_HEX4;
    else k = KIND_HEX8;
    return k;
  endfunction

  function automatic logic [StepW-1:0] last_step(kind_e k);
    logic [StepW-1:0] n;
    unique case (k)
      KIND_LETTER: n = 4'd1;
      KIND_HEX4:   n = 4'd5;
      KIND_HEX8:   n = 4'd9;
      default:     n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [CharW-1:0] hex_digit(logic [3:0] nib);
    logic [CharW-1:0] ch;
    if (nib < 4'd10) ch = 7'h30 + {3'b000, nib};
    else ch = 7'h57 + {3'b000, nib};
    return ch;
  endfunction

endpackage

// ===== rtl/core/uue_byte_if.sv =====
// Input byte channel of the escaper: valid/ready plus one string byte.
// No dependencies.
interface uue_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ===== rtl/core/uue_char_if.sv =====
// Output word channel of the escaper: valid/ready plus one ASCII result word.
// No dependencies.
interface uue_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       char_valid;
  logic       string_done;
  logic       bad_utf8;

  modport source (output valid, output out_char, output char_valid, output string_done,
                  output bad_utf8, input ready);
  modport sink   (input valid, input out_char, input char_valid, input string_done,
                  input bad_utf8, output ready);
endinterface

// ===== rtl/core/uue_cfg_if.sv =====
// Configuration write channel of the escaper: valid/ready, register index, data.
// No dependencies.
interface uue_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/uue_front.sv =====
// Front end: UTF-8 / Latin-1 decoder that turns each byte into at most one job.
// Depends on uue_pkg and uue_byte_if.
module uue_front
  import uue_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  uue_byte_if.sink      byte_i,
  input  logic          full_i,
  output logic          push_o,
  output job_t          job_o
);

  logic [CpW-1:0] pcp_q, pcp_d;
  logic [1:0]     bse_q, bse_d;
  logic [7:0]     lead_q, lead_d;
  logic           start_q, start_d;
  logic           skip_q, skip_d;

  logic           acc;
  logic           have, bad, emit;
  logic [CpW-1:0] cp, pcp_n;
  logic [7:0]     lo, hi, b;
  logic           eos;

  assign byte_i.ready = !full_i;
  assign acc = byte_i.valid && !full_i;
  assign b   = byte_i.in_byte;
  assign eos = byte_i.end_of_string;
  assign pcp_n = {pcp_q[CpW-7:0], b[5:0]};

  always_comb begin
    pcp_d   = pcp_q;
    bse_d   = bse_q;
    lead_d  = lead_q;
    start_d = start_q;
    skip_d  = skip_q;
    push_o  = 1'b0;
    job_o   = '{kind: KIND_MARK, cp: '0, done: 1'b1, bad: 1'b0};
    have    = 1'b0;
    bad     = 1'b0;
    emit    = 1'b0;
    cp      = '0;
    lo      = 8'h80;
    hi      = 8'hbf;
    if (acc) begin
      if (skip_q) begin
        if (eos) begin
          push_o     = 1'b1;
          job_o.bad  = 1'b1;
          skip_d     = 1'b0;
          start_d    = 1'b1;
          pcp_d      = '0;
          bse_d      = '0;
          lead_d     = '0;
        end
      end else begin
        if (cfg_i.latin1) begin
          pcp_d  = '0;
          bse_d  = '0;
          lead_d = '0;
          cp     = {13'd0, b};
          have   = 1'b1;
        end else if (bse_q == 2'd0) begin
          priority if (b < 8'h80) begin
            cp   = {13'd0, b};
            have = 1'b1;
          end else if (b >= 8'hc2 && b <= 8'hdf) begin
            pcp_d  = {16'd0, b[4:0]};
            bse_d  = 2'd1;
            lead_d = b;
          end else if (b >= 8'he0 && b <= 8'hef) begin
            pcp_d  = {17'd0, b[3:0]};
            bse_d  = 2'd2;
            lead_d = b;
          end else if (b >= 8'hf0 && b <= 8'hf4) begin
            pcp_d  = {18'd0, b[2:0]};
            bse_d  = 2'd3;
            lead_d = b;
          end else begin
            bad = 1'b1;
          end
        end else begin
          if (lead_q == LEAD_E0) lo = 8'ha0;
          else if (lead_q == LEAD_ED) hi = 8'h9f;
          else if (lead_q == LEAD_F0) lo = 8'h90;
          else if (lead_q == LEAD_F4) hi = 8'h8f;
          if (b < lo || b > hi) begin
            bad = 1'b1;
          end else begin
            pcp_d  = pcp_n;
            lead_d = '0;
            bse_d  = bse_q - 2'd1;
            if (bse_q == 2'd1) begin
              cp    = pcp_n;
              pcp_d = '0;
              have  = 1'b1;
            end
          end
        end

        if (bad) begin
          pcp_d  = '0;
          bse_d  = '0;
          lead_d = '0;
          if (eos) begin
            push_o    = 1'b1;
            job_o.bad = 1'b1;
            start_d   = 1'b1;
          end else begin
            skip_d = 1'b1;
          end
        end else begin
          emit = have && !(cfg_i.drop_bom && !cfg_i.latin1 && start_q && cp == CP_BOM);
          if (have) start_d = 1'b0;
          if (eos) begin
            push_o = 1'b1;
            if (bse_d != 2'd0) begin
              job_o.bad = 1'b1;
            end else if (emit) begin
              job_o = '{kind: classify(cp), cp: cp, done: 1'b1, bad: 1'b0};
            end
            pcp_d   = '0;
            bse_d   = '0;
            lead_d  = '0;
            start_d = 1'b1;
          end else if (emit) begin
            push_o = 1'b1;
            job_o  = '{kind: classify(cp), cp: cp, done: 1'b0, bad: 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcp_q   <= '0;
      bse_q   <= '0;
      lead_q  <= '0;
      start_q <= 1'b1;
      skip_q  <= 1'b0;
    end else begin
      pcp_q   <= pcp_d;
      bse_q   <= bse_d;
      lead_q  <= lead_d;
      start_q <= start_d;
      skip_q  <= skip_d;
    end
  end

endmodule

// ===== rtl/core/uue_queue.sv =====
// Short job queue between decoder and expander, held in flip-flops.
// Depends on uue_pkg.
module uue_queue
  import uue_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic nonempty_o,
  output job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign nonempty_o = (cnt_q != '0);
  assign job_o      = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/core/uue_back.sv =====
// Back end: expands one job into its escape words, one word per cycle
// while the receiver is ready. Depends on uue_pkg and uue_char_if.
module uue_back
  import uue_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       nonempty_i,
  input  job_t       job_i,
  output logic       pop_o,
  uue_char_if.source char_o
);

  job_t             job_q;
  logic [StepW-1:0] cnt_q;
  logic             busy_q;
  logic [StepW-1:0] last;
  logic             at_last, acc;
  logic [2:0]       nib_idx;
  logic [31:0]      cp_ext;
  logic [3:0]       nib;
  logic [StepW-1:0] rem;

  assign last    = last_step(job_q.kind);
  assign at_last = (cnt_q == last);
  assign acc     = char_o.valid && char_o.ready;
  assign pop_o   = nonempty_i && (!busy_q || (acc && at_last));

  assign rem     = last - cnt_q;
  assign nib_idx = rem[2:0];
  assign cp_ext  = {11'd0, job_q.cp};
  assign nib     = cp_ext[{nib_idx, 2'b00} +: 4];

  assign char_o.valid       = busy_q;
  assign char_o.string_done = job_q.done && at_last;
  assign char_o.bad_utf8    = job_q.bad;

  always_comb begin
    char_o.out_char   = CH_NONE;
    char_o.char_valid = 1'b1;
    unique case (job_q.kind)
      KIND_PLAIN:  char_o.out_char = job_q.cp[CharW-1:0];
      KIND_LETTER: char_o.out_char = (cnt_q == '0) ? CH_BACKSLASH : letter_of(job_q.cp);
      KIND_HEX4, KIND_HEX8: begin
        if (cnt_q == 4'd0) char_o.out_char = CH_BACKSLASH;
        else if (cnt_q == 4'd1) begin
          char_o.out_char = (job_q.kind == KIND_HEX4) ? CH_LOWER_U : CH_UPPER_U;
        end else char_o.out_char = hex_digit(nib);
      end
      default: char_o.char_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (acc) begin
        if (at_last) busy_q <= 1'b0;
        else cnt_q <= cnt_q + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/utf8_unicode_escaper.sv =====
// Flow: the byte that completes a code point is written into the job queue; once the
// expander is free it loads the job into its job register, which drives the first word.
// Throughput: one byte per cycle while each code point yields one word and words are
// taken; a 2-, 6- or 10-word escape holds the expander, the queue fills, input stalls.
// Reset: asynchronous, clears decoder, queue and expander; BOM stripping on, UTF-8 mode.
// Depends on uue_pkg, the three channel interfaces, uue_front, uue_queue, uue_back.
module utf8_unicode_escaper
  import uue_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uue_byte_if.sink   byte_i,
  uue_cfg_if.sink    cfg_i,
  uue_char_if.source char_o
);

  cfg_t cfg_q;
  logic push, full, pop, nonempty;
  job_t job_in, job_out;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{drop_bom: 1'b1, latin1: 1'b0};
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_STRIP_BOM) cfg_q.drop_bom <= cfg_i.data;
      if (cfg_i.index == CFG_LATIN1)    cfg_q.latin1   <= cfg_i.data;
    end
  end

  uue_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .byte_i (byte_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  uue_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .job_i      (job_in),
    .full_o     (full),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .job_o      (job_out)
  );

  uue_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .nonempty_i (nonempty),
    .job_i      (job_out),
    .pop_o      (pop),
    .char_o     (char_o)
  );

endmodule

// ===== rtl/core/uue_checker.sv =====
// Port-level checks on the escaper's output words, bound to the top level.
// Depends on utf8_unicode_escaper_defines.svh.
`include "utf8_unicode_escaper_defines.svh"

module uue_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [6:0] out_char_i,
  input logic       char_valid_i,
  input logic       string_done_i,
  input logic       bad_utf8_i
);

  `UUE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_i && !ready_i, valid_i && $stable(out_char_i))
  `UUE_ASSERT_NOW(a_marker_done, clk_i, rst_ni, valid_i && !char_valid_i, string_done_i && out_char_i == 7'h00)
  `UUE_ASSERT_NOW(a_bad_is_marker, clk_i, rst_ni, valid_i && bad_utf8_i, !char_valid_i && string_done_i)
  `UUE_ASSERT_NOW(a_printable, clk_i, rst_ni, valid_i && char_valid_i, out_char_i >= 7'd32 && out_char_i <= 7'd126)

endmodule

bind utf8_unicode_escaper uue_checker u_uue_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (char_o.valid),
  .ready_i       (char_o.ready),
  .out_char_i    (char_o.out_char),
  .char_valid_i  (char_o.char_valid),
  .string_done_i (char_o.string_done),
  .bad_utf8_i    (char_o.bad_utf8)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for utf8_unicode_escaper: drives strings byte by byte, predicts
// every escaped word in step with the input and checks each word the block returns.
// Depends on uue_pkg and the byte, config and char channel interfaces of the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uue_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam logic [127:0] HEX_CHARS    = "0123456789abcdef";

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             cv;
    logic             done;
    logic             bad;
  } esc_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             src_valid = 1'b0;
  logic [7:0]       src_byte = 8'h00;
  logic             src_eos = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = CFG_STRIP_BOM;
  logic             cfg_data = 1'b0;
  logic             sink_ready = 1'b0;
  logic             holding = 1'b0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      mismatch_cnt = 0;
  int unsigned      cycle_cnt = 0;
  int unsigned      hold_left = 0;
  event             hold_off_ev;

  // predictor state and its copy of the registers
  logic             cfg_strip = 1'b1;
  logic             cfg_latin1 = 1'b0;
  logic [CpW-1:0]   acc_cp = '0;
  logic [1:0]       due_cnt = 2'd0;
  logic [7:0]       lead_b = 8'h00;
  logic             first_cp = 1'b1;
  logic             skip_str = 1'b0;

  esc_word_t        expected_words[$];
  esc_word_t        want;
  logic [7:0]       text_bytes[$];

  uue_byte_if byte_ch ();
  uue_cfg_if  cfg_ch ();
  uue_char_if char_ch ();

  assign byte_ch.valid         = src_valid;
  assign byte_ch.in_byte       = src_byte;
  assign byte_ch.end_of_string = src_eos;
  assign cfg_ch.valid          = cfg_valid;
  assign cfg_ch.index          = cfg_idx;
  assign cfg_ch.data           = cfg_data;
  assign char_ch.ready         = sink_ready;

  utf8_unicode_escaper dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_ch),
    .cfg_i  (cfg_ch),
    .char_o (char_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (holding) begin
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // hold the receiver off for a long stretch
  always begin
    @(hold_off_ev);
    @(negedge clk);
    holding = 1'b1;
    for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(negedge clk);
    holding = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, exp_val, $realtime);
    mismatch_cnt++;
  endtask

  // a word seen valid and ready at the falling edge is taken at the next rising edge
  always @(negedge clk) begin
    if (rst_n && char_ch.valid && char_ch.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 32'(char_ch.out_char), 0);
      end else begin
        want = expected_words.pop_front();
        if (char_ch.out_char !== want.ch)
          report_mismatch("out_char", 32'(char_ch.out_char), 32'(want.ch));
        if (char_ch.char_valid !== want.cv)
          report_mismatch("char_valid", 32'(char_ch.char_valid), 32'(want.cv));
        if (char_ch.string_done !== want.done)
          report_mismatch("string_done", 32'(char_ch.string_done), 32'(want.done));
        if (char_ch.bad_utf8 !== want.bad)
          report_mismatch("bad_utf8", 32'(char_ch.bad_utf8), 32'(want.bad));
      end
    end
  end

  function automatic void push_word(input logic [CharW-1:0] ch, input logic cv,
                                    input logic done, input logic bad);
    esc_word_t w;
    w.ch = ch;
    w.cv = cv;
    w.done = done;
    w.bad = bad;
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic logic [7:0] escape_letter(input logic [CpW-1:0] cp);
    logic [7:0] letter;
    case (cp)
      21'h07:  letter = "a";
      21'h08:  letter = "b";
      21'h09:  letter = "t";
      21'h0a:  letter = "n";
      21'h0b:  letter = "v";
      21'h0c:  letter = "f";
      21'h0d:  letter = "r";
      21'h22:  letter = "\"";
      21'h27:  letter = "'";
      21'h5c:  letter = "\\";
      default: letter = 8'h00;
    endcase
    return letter;
  endfunction

  function automatic int push_escape(input logic [CpW-1:0] cp);
    logic [7:0]  letter;
    logic [31:0] cp32;
    logic [3:0]  nib;
    int          digits;
    letter = escape_letter(cp);
    cp32 = {11'd0, cp};
    if (letter != 8'h00) begin
      push_word(CH_BACKSLASH, 1'b1, 1'b0, 1'b0);
      push_word(letter[CharW-1:0], 1'b1, 1'b0, 1'b0);
      return 2;
    end
    if (cp >= CP_PRINT_LO && cp <= CP_PRINT_HI) begin
      push_word(cp[CharW-1:0], 1'b1, 1'b0, 1'b0);
      return 1;
    end
    push_word(CH_BACKSLASH, 1'b1, 1'b0, 1'b0);
    if (cp <= CP_BMP_MAX) begin
      push_word(CH_LOWER_U, 1'b1, 1'b0, 1'b0);
      digits = 4;
    end else begin
      push_word(CH_UPPER_U, 1'b1, 1'b0, 1'b0);
      digits = 8;
    end
    for (int sh = digits - 1; sh >= 0; sh--) begin
      nib = cp32[sh*4 +: 4];
      push_word(HEX_CHARS[(15 - int'(nib)) * 8 +: CharW], 1'b1, 1'b0, 1'b0);
    end
    return digits + 2;
  endfunction

  function automatic void clear_decoder();
    acc_cp = '0;
    due_cnt = 2'd0;
    lead_b = 8'h00;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic eos);
    logic [CpW-1:0] cp;
    logic           have;
    logic           bad;
    logic [7:0]     lo;
    logic [7:0]     hi;
    int             produced;
    cp = '0;
    have = 1'b0;
    bad = 1'b0;
    lo = 8'h80;
    hi = 8'hbf;
    produced = 0;
    if (skip_str) begin
      if (eos) begin
        push_word(CH_NONE, 1'b0, 1'b1, 1'b1);
        skip_str = 1'b0;
        first_cp = 1'b1;
        clear_decoder();
      end
      return;
    end
    if (cfg_latin1) begin
      clear_decoder();
      cp = {13'd0, b};
      have = 1'b1;
    end else if (due_cnt == 2'd0) begin
      if (b < 8'h80) begin
        cp = {13'd0, b};
        have = 1'b1;
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
        acc_cp = {16'd0, b[4:0]};
        due_cnt = 2'd1;
        lead_b = b;
      end else if (b >= 8'he0 && b <= 8'hef) begin
        acc_cp = {17'd0, b[3:0]};
        due_cnt = 2'd2;
        lead_b = b;
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
        acc_cp = {18'd0, b[2:0]};
        due_cnt = 2'd3;
        lead_b = b;
      end else begin
        bad = 1'b1;
      end
    end else begin
      if (lead_b == LEAD_E0) lo = 8'ha0;
      else if (lead_b == LEAD_ED) hi = 8'h9f;
      else if (lead_b == LEAD_F0) lo = 8'h90;
      else if (lead_b == LEAD_F4) hi = 8'h8f;
      if (b < lo || b > hi) begin
        bad = 1'b1;
      end else begin
        acc_cp = {acc_cp[CpW-7:0], b[5:0]};
        lead_b = 8'h00;
        due_cnt = due_cnt - 2'd1;
        if (due_cnt == 2'd0) begin
          cp = acc_cp;
          acc_cp = '0;
          have = 1'b1;
        end
      end
    end
    if (bad) begin
      clear_decoder();
      if (eos) begin
        push_word(CH_NONE, 1'b0, 1'b1, 1'b1);
        first_cp = 1'b1;
      end else begin
        skip_str = 1'b1;
      end
      return;
    end
    if (have) begin
      if (!(cfg_strip && !cfg_latin1 && first_cp && cp == CP_BOM))
        produced = push_escape(cp);
      first_cp = 1'b0;
    end
    if (eos) begin
      if (due_cnt != 2'd0) push_word(CH_NONE, 1'b0, 1'b1, 1'b1);
      else if (produced > 0) expected_words[expected_words.size() - 1].done = 1'b1;
      else push_word(CH_NONE, 1'b0, 1'b1, 1'b0);
      clear_decoder();
      first_cp = 1'b1;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_byte  <= b;
    src_eos   <= eos;
    do @(negedge clk); while (!byte_ch.ready);
    @(posedge clk);
    predict_byte(b, eos);
  endtask

  task automatic drain_results();
    src_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_cfg(input logic strip, input logic latin1);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_idx   <= CFG_STRIP_BOM;
    cfg_data  <= strip;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
    cfg_strip = strip;
    cfg_idx   <= CFG_LATIN1;
    cfg_data  <= latin1;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
    cfg_latin1 = latin1;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic send_text();
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  function automatic logic [CpW-1:0] rand_cp();
    logic [CpW-1:0] cp;
    case ($urandom_range(9))
      0, 1, 2, 3: cp = CpW'($urandom_range(126, 32));
      4: cp = ($urandom_range(3) == 0) ? 21'h7f : CpW'($urandom_range(31, 0));
      5: cp = CpW'($urandom_range(32'h7ff, 32'h80));
      6: begin
        cp = CpW'($urandom_range(32'hffff, 32'h800));
        if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h1000;
      end
      7: cp = CpW'($urandom_range(32'h10ffff, 32'h10000));
      8: begin
        case ($urandom_range(9))
          0: cp = 21'h7f;
          1: cp = 21'h80;
          2: cp = 21'h7ff;
          3: cp = 21'h800;
          4: cp = 21'hd7ff;
          5: cp = 21'he000;
          6: cp = 21'hffff;
          7: cp = 21'h10000;
          8: cp = 21'h10ffff;
          default: cp = CP_BOM;
        endcase
      end
      default: begin
        case ($urandom_range(2))
          0: cp = 21'h22;
          1: cp = 21'h27;
          default: cp = 21'h5c;
        endcase
      end
    endcase
    return cp;
  endfunction

  function automatic void add_text_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endfunction

  function automatic void push_utf8(input logic [CpW-1:0] cp);
    if (cp < 21'h80) begin
      add_text_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_text_byte({3'b110, cp[10:6]});
      add_text_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_text_byte({4'b1110, cp[15:12]});
      add_text_byte({2'b10, cp[11:6]});
      add_text_byte({2'b10, cp[5:0]});
    end else begin
      add_text_byte({5'b11110, cp[20:18]});
      add_text_byte({2'b10, cp[17:12]});
      add_text_byte({2'b10, cp[11:6]});
      add_text_byte({2'b10, cp[5:0]});
    end
  endfunction

  // mostly well-formed text; the rest broken, cut short or noise
  function automatic void build_text();
    int n;
    text_bytes.delete();
    if ($urandom_range(7) == 0) push_utf8(CP_BOM);
    n = $urandom_range(5, 1);
    repeat (n) push_utf8(rand_cp());
    case ($urandom_range(15))
      0: text_bytes[$urandom_range(text_bytes.size() - 1)] = 8'($urandom_range(255));
      1: if (text_bytes.size() > 1) void'(text_bytes.pop_back());
      2: text_bytes.insert($urandom_range(text_bytes.size() - 1),
                           8'($urandom_range(8'hbf, 8'h80)));
      3: begin
        case ($urandom_range(6))
          0: begin add_text_byte(8'he0); add_text_byte(8'h9f); end
          1: begin add_text_byte(8'hed); add_text_byte(8'ha0); end
          2: begin add_text_byte(8'hf0); add_text_byte(8'h8f); end
          3: begin add_text_byte(8'hf4); add_text_byte(8'h90); end
          4: add_text_byte(8'hc1);
          5: add_text_byte(8'hf5);
          default: add_text_byte(8'h80);
        endcase
        push_utf8(rand_cp());
      end
      4: begin
        text_bytes.delete();
        repeat ($urandom_range(4, 1)) add_text_byte(8'($urandom_range(255)));
      end
      default: ;
    endcase
  endfunction

  task automatic test_escape_letters();
    logic [7:0] ctl[10] = '{8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d,
                            8'h22, 8'h27, 8'h5c};
    foreach (ctl[i]) send_byte(ctl[i], i == 9);
  endtask

  task automatic test_ascii_edges();
    send_byte(8'h00, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h7e, 1'b0);
    send_byte(8'h7f, 1'b1);
  endtask

  task automatic test_bom_strip();
    set_cfg(1'b1, 1'b0);
    send_byte(8'hef, 1'b0);
    send_byte(8'hbb, 1'b0);
    send_byte(8'hbf, 1'b1);
  endtask

  task automatic test_supplementary();
    send_byte(8'hf4, 1'b0);
    send_byte(8'h8f, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b1);
  endtask

  task automatic test_invalid_utf8();
    send_byte(8'hc0, 1'b1);
    send_byte(8'he0, 1'b1);
  endtask

  task automatic test_mode_change();
    send_byte(8'hc3, 1'b0);
    set_cfg(1'b1, 1'b1);
    send_byte(8'hff, 1'b1);
    set_cfg(1'b1, 1'b0);
    send_byte(8'hf5, 1'b0);
    set_cfg(1'b0, 1'b1);
    send_byte(8'h41, 1'b1);
    set_cfg(1'b1, 1'b0);
  endtask

  task automatic test_random_text(input int unsigned n_bytes);
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(7) == 0) set_cfg(1'($urandom_range(1)), $urandom_range(3) == 0);
      build_text();
      send_text();
      sent += text_bytes.size();
    end
  endtask

  // fill the block while the receiver holds off, then pause until it empties
  task automatic test_backpressure();
    -> hold_off_ev;
    for (int k = 0; k < 16; k++) send_byte(8'h01, (k % 4) == 3);
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idle(16, 60);
    test_escape_letters();
    test_ascii_edges();
    test_bom_strip();
    test_supplementary();
    test_invalid_utf8();
    test_mode_change();
    test_random_text(50);
    set_idle(60, 16);
    test_random_text(50);
    set_idle(0, 0);
    test_backpressure();
    test_random_text(50);
    drain_results();
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
